### design/fee_pkg.sv
package fee_pkg;

    localparam int OP_W        = 2;
    localparam int IDX_W       = 15;
    localparam int AMT_W       = 2;
    localparam int HEAT_W      = 6;
    localparam int COLOR_W     = 32;
    localparam int CFG_WIDTH_W  = 9;
    localparam int CFG_HEIGHT_W = 8;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    // stream payload layout, zero padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SPREAD = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 9'd256;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 8'd128;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_INIT
    } state_t;

    typedef struct packed {
        logic item_load;
        logic clear_write;
        logic init_write;
        logic cursor_inc;
        logic cursor_clear;
        logic spread_exec;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            clear_last;
        logic            init_last;
        logic            out_busy;
    } dp_status_t;

    function automatic logic [COLOR_W-1:0] fire_palette(input logic [HEAT_W-1:0] heat);
        logic [COLOR_W-1:0] c;
        unique case (heat)
            6'd0:  c = 32'h00070707;
            6'd1:  c = 32'hFF1F0707;
            6'd2:  c = 32'hFF2F0F07;
            6'd3:  c = 32'hFF470F07;
            6'd4:  c = 32'hFF571707;
            6'd5:  c = 32'hFF671F07;
            6'd6:  c = 32'hFF771F07;
            6'd7:  c = 32'hFF8F2707;
            6'd8:  c = 32'hFF9F2F07;
            6'd9:  c = 32'hFFAF3F07;
            6'd10: c = 32'hFFBF4707;
            6'd11: c = 32'hFFC74707;
            6'd12: c = 32'hFFDF4F07;
            6'd13: c = 32'hFFDF5707;
            6'd14: c = 32'hFFDF5707;
            6'd15: c = 32'hFFD75F07;
            6'd16: c = 32'hFFD75F07;
            6'd17: c = 32'hFFD7670F;
            6'd18: c = 32'hFFCF6F0F;
            6'd19: c = 32'hFFCF770F;
            6'd20: c = 32'hFFCF7F0F;
            6'd21: c = 32'hFFCF8717;
            6'd22: c = 32'hFFC78717;
            6'd23: c = 32'hFFC78F17;
            6'd24: c = 32'hFFC7971F;
            6'd25: c = 32'hFFBF9F1F;
            6'd26: c = 32'hFFBF9F1F;
            6'd27: c = 32'hFFBFA727;
            6'd28: c = 32'hFFBFA727;
            6'd29: c = 32'hFFBFAF2F;
            6'd30: c = 32'hFFB7AF2F;
            6'd31: c = 32'hFFB7B72F;
            6'd32: c = 32'hFFB7B737;
            6'd33: c = 32'hFFCFCF6F;
            6'd34: c = 32'hFFDFDF9F;
            6'd35: c = 32'hFFEFEFC7;
            6'd36: c = 32'hFFFFFFFF;
            default: c = 32'h00000000;
        endcase
        return c;
    endfunction

endpackage

### design/fee_ram.sv
module fee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/fee_ctrl.sv
module fee_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fee_pkg::dp_status_t status,
    output fee_pkg::ctrl_cmd_t  cmd
);

    import fee_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_write = 1'b1;
                cmd.cursor_inc  = 1'b1;
                if (status.clear_last) begin
                    cmd.cursor_clear = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.op)
                    OP_INIT: begin
                        state_next = ST_INIT;
                    end
                    OP_SPREAD: begin
                        cmd.spread_exec = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    OP_READ: begin
                        // hold the item until the output register can take it
                        if (!status.out_busy) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_INIT: begin
                cmd.init_write = 1'b1;
                cmd.cursor_inc = 1'b1;
                if (status.init_last) begin
                    cmd.cursor_clear = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/fee_datapath.sv
module fee_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128,
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fee_pkg::ctrl_cmd_t                  cmd,
    output fee_pkg::dp_status_t                 status,
    input  logic                                cfg_wr_en,
    input  logic [fee_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [fee_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [fee_pkg::OP_W-1:0]            s_opcode,
    input  logic [fee_pkg::IDX_W-1:0]           s_pixel_index,
    input  logic [fee_pkg::AMT_W-1:0]           s_spread_amount,
    output logic                                ram_rd_en,
    output logic [ADDR_W-1:0]                   ram_rd_addr,
    input  logic [fee_pkg::HEAT_W-1:0]          ram_rd_data,
    output logic                                ram_wr_en,
    output logic [ADDR_W-1:0]                   ram_wr_addr,
    output logic [fee_pkg::HEAT_W-1:0]          ram_wr_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fee_pkg::HEAT_W-1:0]          m_heat_value,
    output logic [fee_pkg::COLOR_W-1:0]         m_argb_color
);

    import fee_pkg::*;

    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam int TW = EW + EH;
    localparam int CW = (TW > 16) ? TW : 16;

    logic [CFG_WIDTH_W-1:0]  cfg_width_reg;
    logic [CFG_HEIGHT_W-1:0] cfg_height_reg;

    logic [EW-1:0] eff_w;
    logic [EH-1:0] eff_h;
    logic [TW-1:0] total_next;
    logic [TW-1:0] bottom_next;
    logic [EW-1:0] eff_w_reg;
    logic [TW-1:0] total_reg;
    logic [TW-1:0] bottom_reg;

    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [AMT_W-1:0] amt_reg;

    logic [TW-1:0] cursor_reg;
    logic [TW-1:0] cursor_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [HEAT_W-1:0] heat_out_reg;
    logic [COLOR_W-1:0] color_out_reg;

    logic [CW-1:0]     idx_ext;
    logic [CW-1:0]     lhs;
    logic [CW-1:0]     rhs;
    logic [CW-1:0]     to_addr;
    logic              in_frame;
    logic              in_store;
    logic              spread_ok;
    logic [HEAT_W-1:0] src_heat;
    logic [HEAT_W-1:0] target_heat;
    logic [HEAT_W-1:0] read_heat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= FRAME_WIDTH_RST;
            cfg_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_wr_data;
                REG_FRAME_HEIGHT: cfg_height_reg <= cfg_wr_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb begin
        if (cfg_width_reg == '0) begin
            eff_w = EW'(1);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(cfg_width_reg);
        end
        if (32'(cfg_height_reg) < 2) begin
            eff_h = EH'(2);
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = EH'(cfg_height_reg);
        end
        total_next  = TW'(eff_w) * TW'(eff_h);
        bottom_next = total_next - TW'(eff_w);
    end

    // clamped geometry is registered behind the config registers
    always_ff @(posedge aclk) begin
        eff_w_reg  <= eff_w;
        total_reg  <= total_next;
        bottom_reg <= bottom_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg  <= s_opcode;
            idx_reg <= s_pixel_index;
            amt_reg <= s_spread_amount;
        end
    end

    // sweep cursor, shared by the clearing pass and init
    always_comb begin
        cursor_next = cursor_reg;
        if (cmd.cursor_clear) begin
            cursor_next = '0;
        end else if (cmd.cursor_inc) begin
            cursor_next = cursor_reg + TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

    // spread / read decode, against the item's registered fields
    always_comb begin
        idx_ext   = CW'(idx_reg);
        in_frame  = idx_ext < CW'(total_reg);
        in_store  = 32'(idx_reg) < DEPTH;
        lhs       = idx_ext + CW'(1);
        rhs       = CW'(eff_w_reg) + CW'(amt_reg);
        to_addr   = lhs - rhs;
        spread_ok = in_frame && in_store && (idx_ext >= CW'(eff_w_reg))
                    && (lhs >= rhs) && (32'(to_addr) < DEPTH);

        src_heat = ram_rd_data;
        if (src_heat >= HEAT_W'(amt_reg)) begin
            target_heat = src_heat - HEAT_W'(amt_reg);
        end else begin
            target_heat = '0;
        end
        if (target_heat > HEAT_MAX) begin
            target_heat = '0;
        end

        read_heat = (ram_rd_data > HEAT_MAX) ? HEAT_MAX : ram_rd_data;
    end

    assign ram_rd_en   = cmd.item_load;
    assign ram_rd_addr = ADDR_W'(s_pixel_index);

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cursor_reg[ADDR_W-1:0];
        ram_wr_data = '0;
        priority if (cmd.clear_write) begin
            ram_wr_en = 1'b1;
        end else if (cmd.init_write) begin
            ram_wr_en   = 32'(cursor_reg) < DEPTH;
            ram_wr_data = (cursor_reg >= bottom_reg) ? HEAT_MAX : '0;
        end else if (cmd.spread_exec) begin
            ram_wr_en   = spread_ok;
            ram_wr_addr = to_addr[ADDR_W-1:0];
            ram_wr_data = target_heat;
        end else begin
            ram_wr_en = 1'b0;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (in_frame && in_store) begin
                heat_out_reg  <= read_heat;
                color_out_reg <= fire_palette(read_heat);
            end else begin
                heat_out_reg  <= '0;
                color_out_reg <= '0;
            end
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_heat_value = heat_out_reg;
    assign m_argb_color = color_out_reg;

    assign status.op         = op_reg;
    assign status.clear_last = cursor_reg == TW'(DEPTH - 1);
    assign status.init_last  = cursor_reg == (total_reg - TW'(1));
    assign status.out_busy   = m_valid_reg && !m_tready;

endmodule

### design/fire_effect_frame_engine.sv
// Fire-effect frame engine: a frame of heat cells (0..36) in an on-chip memory.
// Input stream (s_*): one item per operation. Opcode init fills the frame
// (bottom row 36, rest 0); spread copies a cell, decayed by r, one row up and
// shifted sideways by 1 - r; read returns the cell's heat and palette color.
// Output stream (m_*): one item per read, none for init and spread.
// Frame size comes from the write-only config port (index 0 width, 1 height).
// Spread and read: the item is taken in idle and the heat memory read, then
// exec decodes it and writes the single-write-port memory; a read may wait in
// exec. Init goes on from exec to write one cell per cycle over width * height
// cells. New items are taken only in idle; m_tvalid is registered from exec.
// Reset: the heat memory is swept to zero, all MAX_WIDTH * MAX_HEIGHT cells
// (32768 at the defaults), with s_tready low; config writes are taken meanwhile.
// A stalled m_tready holds the result in the output register; a later item is
// still accepted and only a second read waits for the register to drain.
module fire_effect_frame_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] opcode, [16:2] pixel_index, [18:17] spread_amount
    input  logic [fee_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] heat_value, [37:6] argb_color
    output logic [fee_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [fee_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [fee_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    import fee_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [HEAT_W-1:0]   ram_rd_data;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [HEAT_W-1:0]   ram_wr_data;
    logic [HEAT_W-1:0]   m_heat_value;
    logic [COLOR_W-1:0]  m_argb_color;

    fee_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fee_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_opcode        (s_tdata[1:0]),
        .s_pixel_index   (s_tdata[16:2]),
        .s_spread_amount (s_tdata[18:17]),
        .ram_rd_en       (ram_rd_en),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_heat_value    (m_heat_value),
        .m_argb_color    (m_argb_color)
    );

    fee_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (DEPTH)
    ) u_heat_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tdata = {2'b00, m_argb_color, m_heat_value};

endmodule
